// ===== hdl/rpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_pkg: shared types and constants of the packet airtime calculator
// Register indexes, bandwidth codes, reciprocal tables and stage controls.
// ----------------------------------------------------------------------------
package rpa_pkg;

    // Number of register stages from input transaction to output register.
    localparam int unsigned STAGES = 7;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_SF  = 2'd0,
        REG_BW  = 2'd1,
        REG_CR  = 2'd2,
        REG_CRC = 2'd3
    } t_cfg_reg;

    // Bandwidth select codes.
    typedef enum logic [1:0] {
        BW_125     = 2'd0,
        BW_250     = 2'd1,
        BW_500     = 2'd2,
        BW_125_ALT = 2'd3
    } t_bw;

    localparam logic [3:0] SF_MIN     = 4'd6;
    localparam logic [3:0] SF_MAX     = 4'd12;
    localparam logic [3:0] SF_LDRO    = 4'd11;
    localparam logic [3:0] CR_MIN     = 4'd5;
    localparam logic [3:0] CR_MAX     = 4'd8;
    localparam logic [3:0] PAY_FIXED  = 4'd8;
    localparam logic [5:0] PRE_QTRS   = 6'd49;
    localparam logic [4:0] HDR_BITS   = 5'd28;
    localparam logic [4:0] CRC_BITS   = 5'd16;

    // Millisecond conversion: v / 125 as (v * floor(2^22 / 125)) >> 22,
    // then one correction step.
    localparam int unsigned MS_SHIFT  = 22;
    localparam logic [15:0] MS_RECIP  = 16'd33554;
    localparam logic [6:0]  MS_DIV    = 7'd125;

    // Payload quotient: n / k as (n * floor(2^16 / k)) >> 16, plus correction.
    localparam int unsigned SYM_SHIFT = 16;

    typedef struct packed {
        logic load_mul;
        logic load_fix;
    } t_ms_ctl;

    function automatic logic [13:0] f_sym_recip(input logic [3:0] k);
        logic [13:0] r;
        case (k)
            4'd6:    r = 14'd10922;
            4'd7:    r = 14'd9362;
            4'd8:    r = 14'd8192;
            4'd9:    r = 14'd7281;
            4'd10:   r = 14'd6553;
            4'd11:   r = 14'd5957;
            4'd12:   r = 14'd5461;
            default: r = 14'd8192;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/rpa_ms_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_ms_div: two-stage division of the scaled quarter-symbol count by 125
// A reciprocal multiply gives an estimate that is exact or one low; the
// second stage corrects it with one compare.
// ----------------------------------------------------------------------------
module rpa_ms_div
    import rpa_pkg::*;
(
    input  logic        i_clk,
    input  t_ms_ctl     i_ctl,
    input  logic [21:0] i_value,
    output logic [15:0] o_ms
);

    logic [21:0] r_mul_value;
    logic [15:0] r_mul_est;
    logic [15:0] r_ms;
    logic [37:0] n_prod;
    logic [22:0] n_back;
    logic [21:0] n_rem;
    logic [15:0] n_ms;

    always_comb begin
        n_prod = 38'(i_value) * 38'(MS_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_mul) begin
            r_mul_value <= i_value;
            r_mul_est   <= n_prod[MS_SHIFT +: 16];
        end
    end

    always_comb begin
        n_back = 23'(r_mul_est) * 23'(MS_DIV);
        n_rem  = r_mul_value - n_back[21:0];
        n_ms   = (n_rem >= 22'(MS_DIV)) ? r_mul_est + 16'd1 : r_mul_est;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_fix) begin
            r_ms <= n_ms;
        end
    end

    assign o_ms = r_ms;

endmodule

// ===== hdl/radio_packet_airtime.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_packet_airtime: time on air of one chirp-spread-spectrum packet
// Computes milliseconds on air and payload symbol count from a byte length.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one payload length in bytes per transaction. For
// each one the master stream returns exactly one transaction holding the
// packet's time on air in whole milliseconds and its payload symbol count.
// Modem settings come through the write port (index 0 spreading factor,
// 1 bandwidth select, 2 coding denominator, 3 CRC enable) and must only be
// changed while no transaction is in flight.
// The datapath is a seven-stage pipeline: clamping and the ceiling numerator,
// a reciprocal multiply for the symbol quotient, its correction, the coding
// rate multiply, the shift by the spreading factor, and a two-stage divide
// by 125. A result is presented once its transaction reaches the seventh
// stage. A new length is accepted every cycle unless a stalled master side
// has filled the pipeline.
// Each stage holds a valid bit and loads whenever it is empty or the stage
// after it moves, so a stalled master side lets the pipeline fill up to
// seven transactions before the slave ready drops; nothing is lost or
// repeated. Synchronous reset clears the valid bits and restores the
// settings to spreading factor 7, 125 kHz, coding 4/5 and CRC enabled.
// ----------------------------------------------------------------------------
module radio_packet_airtime
    import rpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [3:0]  i_cfg_wdata,
    // Slave stream. tdata: [7:0] payload_length.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    // Master stream. tdata: [13:0] airtime_ms, [23:14] payload_symbols.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata
);

    // Settings registers.
    logic [3:0] r_sf;
    logic [1:0] r_bw;
    logic [3:0] r_cr;
    logic       r_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf  <= 4'd7;
            r_bw  <= BW_125;
            r_cr  <= 4'd5;
            r_crc <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_SF:  r_sf  <= i_cfg_wdata;
                REG_BW:  r_bw  <= i_cfg_wdata[1:0];
                REG_CR:  r_cr  <= i_cfg_wdata;
                REG_CRC: r_crc <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Effective settings. Out-of-range spreading factors clamp to the
    // nearest limit, an invalid coding denominator acts as 5, and only
    // select 0 with a spreading factor of 11 or more enables low-data-rate mode.
    logic [3:0] w_sf;
    logic [3:0] w_cr;
    logic       w_ldro;
    logic [3:0] w_k;
    logic [3:0] w_shift;

    always_comb begin
        if (r_sf < SF_MIN) begin
            w_sf = SF_MIN;
        end else if (r_sf > SF_MAX) begin
            w_sf = SF_MAX;
        end else begin
            w_sf = r_sf;
        end
        w_cr   = (r_cr < CR_MIN || r_cr > CR_MAX) ? CR_MIN : r_cr;
        w_ldro = (w_sf >= SF_LDRO) && (t_bw'(r_bw) == BW_125);
        // The symbol denominator is 4 * k.
        w_k    = w_ldro ? w_sf - 4'd2 : w_sf;
        // Quarter-symbols times 2^SF over 500*m equals quarter-symbols
        // shifted by SF - 2 - log2(m), then divided by 125.
        case (t_bw'(r_bw))
            BW_250:  w_shift = w_sf - 4'd3;
            BW_500:  w_shift = w_sf - 4'd4;
            default: w_shift = w_sf - 4'd2;
        endcase
    end

    // Handshake: a stage advances when it is empty or its successor moves.
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_adv;

    always_comb begin
        w_adv[STAGES-1] = !r_vld[STAGES-1] || i_m_axis_tready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            w_adv[i] = !r_vld[i] || w_adv[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (w_adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign o_s_axis_tready = w_adv[0];
    assign o_m_axis_tvalid = r_vld[STAGES-1];

    // Stage 1: ceiling numerator. With a non-positive bit count the
    // numerator is zero, which makes the quotient zero.
    logic [11:0] n_pos;
    logic [5:0]  n_neg;
    logic [11:0] n_sum;
    logic [9:0]  n_s1_num;
    logic [9:0]  r_s1_num;
    logic [3:0]  r_s1_k;

    always_comb begin
        n_pos    = {1'b0, i_s_axis_tdata, 3'b000} + 12'(HDR_BITS)
                 + (r_crc ? 12'(CRC_BITS) : 12'd0);
        n_neg    = {w_sf, 2'b00};
        n_sum    = n_pos - 12'(n_neg) + 12'({w_k, 2'b00}) - 12'd1;
        n_s1_num = (n_pos > 12'(n_neg)) ? n_sum[11:2] : 10'd0;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s1_num <= n_s1_num;
            r_s1_k   <= w_k;
        end
    end

    // Stage 2: reciprocal estimate of num / k, exact or one low.
    logic [23:0] n_s2_prod;
    logic [9:0]  r_s2_num;
    logic [3:0]  r_s2_k;
    logic [6:0]  r_s2_est;

    always_comb begin
        n_s2_prod = 24'(r_s1_num) * 24'(f_sym_recip(r_s1_k));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s2_num <= r_s1_num;
            r_s2_k   <= r_s1_k;
            r_s2_est <= n_s2_prod[SYM_SHIFT +: 7];
        end
    end

    // Stage 3: correct the estimate.
    logic [10:0] n_s3_back;
    logic [9:0]  n_s3_rem;
    logic [6:0]  r_s3_quot;

    always_comb begin
        n_s3_back = 11'(r_s2_est) * 11'(r_s2_k);
        n_s3_rem  = r_s2_num - n_s3_back[9:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s3_quot <= (n_s3_rem >= 10'(r_s2_k)) ? r_s2_est + 7'd1 : r_s2_est;
        end
    end

    // Stage 4: payload symbols.
    logic [10:0] n_s4_nsym;
    logic [9:0]  r_s4_nsym;

    always_comb begin
        n_s4_nsym = 11'(r_s3_quot) * 11'(w_cr) + 11'(PAY_FIXED);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_s4_nsym <= n_s4_nsym[9:0];
        end
    end

    // Stage 5: quarter-symbols scaled by the chip count and bandwidth.
    logic [11:0] n_s5_qtrs;
    logic [21:0] r_s5_value;
    logic [9:0]  r_s5_nsym;

    always_comb begin
        n_s5_qtrs = {r_s4_nsym, 2'b00} + 12'(PRE_QTRS);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_s5_value <= 22'(n_s5_qtrs) << w_shift;
            r_s5_nsym  <= r_s4_nsym;
        end
    end

    // Stages 6 and 7: divide by 125 to get milliseconds.
    t_ms_ctl     w_ms_ctl;
    logic [15:0] w_ms;
    logic [9:0]  r_s6_nsym;
    logic [9:0]  r_s7_nsym;

    assign w_ms_ctl.load_mul = w_adv[5];
    assign w_ms_ctl.load_fix = w_adv[6];

    rpa_ms_div u_ms_div (
        .i_clk   (i_clk),
        .i_ctl   (w_ms_ctl),
        .i_value (r_s5_value),
        .o_ms    (w_ms)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_s6_nsym <= r_s5_nsym;
        end
        if (w_adv[6]) begin
            r_s7_nsym <= r_s6_nsym;
        end
    end

    assign o_m_axis_tdata = {r_s7_nsym, w_ms[13:0]};

endmodule
